@@ hdl/pcos_pkg.sv @@
// ----------------------------------------------------------------------------
// pcos_pkg: shared types and constants of the clock offset smoother
// Word formats, mode codes and fixed-point widths used by the smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package pcos_pkg;

	localparam int SLOT_W  = 4;
	localparam int STAMP_W = 64;
	localparam int ALPHA_W = 17;

	// Number of slots that the 4-bit slot field can address
	localparam int SLOT_LIMIT        = 2 ** SLOT_W;
	localparam int NUM_SLOTS_DEFAULT = 16;

	// Q16 weights
	localparam int                 Q_SHIFT     = 16;
	localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

	// Blend datapath: 33x18 signed partial products into an 82-bit sum
	localparam int HALF_W  = 32;
	localparam int MUL_X_W = HALF_W + 1;
	localparam int MUL_M_W = ALPHA_W + 1;
	localparam int PROD_W  = MUL_X_W + MUL_M_W;
	localparam int ACC_W   = STAMP_W + MUL_M_W;

	// Round-half-away bias: half for positive sums, half minus one for negative
	localparam logic [ACC_W-1:0] BIAS_POS = ACC_W'(32768);
	localparam logic [ACC_W-1:0] BIAS_NEG = ACC_W'(32767);

	// Mode codes
	localparam logic [1:0] MODE_OBSERVE = 2'd0;
	localparam logic [1:0] MODE_CONVERT = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;
	localparam logic [1:0] MODE_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0]                mode;
		logic [SLOT_W-1:0]         sensor_slot;
		logic signed [STAMP_W-1:0] device_stamp;
		logic signed [STAMP_W-1:0] host_stamp;
	} in_word_t;

	typedef struct packed {
		logic signed [STAMP_W-1:0] host_estimate;
		logic signed [STAMP_W-1:0] offset_value;
		logic                      slot_known;
	} out_word_t;

endpackage

`default_nettype wire

@@ hdl/pcos_ram.sv @@
// ----------------------------------------------------------------------------
// pcos_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcos_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/per_sensor_clock_offset_smoother.sv @@
// ----------------------------------------------------------------------------
// per_sensor_clock_offset_smoother: per-slot smoothed device-to-host offset
// Table of 64-bit offsets in a RAM, valid bits in flops, EMA blend unit.
// ----------------------------------------------------------------------------
// One word is processed at a time; in_stall is low only while the block is
// idle. A clear word is handled in the idle state; an observe of an unknown
// or out-of-range slot passes through the lookup state; convert and read go
// on to the response state and wait there while out_stall holds the output
// register; an observe of a known slot runs the multiply, accumulate and
// round states. The offset RAM read data is registered, and the blend
// (65536-a)*old + a*obs is formed by one shared 33x18 multiplier over four
// partial products, then accumulated and rounded. Slot valid bits sit in
// flops and a clear word drops all of them together. The finished result sits
// in an output register, so a pending result does not hold off an observe or clear word.
`default_nettype none

module per_sensor_clock_offset_smoother #(
	parameter int NUM_SLOTS = pcos_pkg::NUM_SLOTS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire pcos_pkg::in_word_t        in_word,
	// output channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output pcos_pkg::out_word_t            out_word,
	// alpha register write port
	input  wire logic                      cfg_wr_en,
	input  wire logic [pcos_pkg::ALPHA_W-1:0] cfg_wr_data
);

	// Only slots below both NUM_SLOTS and the slot field's reach get storage
	localparam int DEPTH = (NUM_SLOTS < pcos_pkg::SLOT_LIMIT) ? NUM_SLOTS
	                                                          : pcos_pkg::SLOT_LIMIT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,   // RAM data valid, decide
		S_MUL,    // four partial products
		S_ACC,    // last partial product into the sum
		S_ROUND,  // round and write back
		S_RESP    // load output register
	} state_t;

	state_t state_q;

	logic [pcos_pkg::ALPHA_W-1:0] alpha_q;
	logic [DEPTH-1:0]             valid_q;

	// Item held while it is worked on
	logic [1:0]                    mode_q;
	logic [AW-1:0]                 idx_q;
	logic                          in_range_q;
	logic [pcos_pkg::STAMP_W-1:0]  dev_q;
	logic [pcos_pkg::STAMP_W-1:0]  obs_q;
	logic [pcos_pkg::STAMP_W-1:0]  old_q;
	logic [pcos_pkg::STAMP_W-1:0]  off_q;
	logic                          known_q;
	logic [pcos_pkg::ALPHA_W-1:0]  a_q;
	logic [pcos_pkg::ALPHA_W-1:0]  inv_a_q;

	// Blend datapath
	logic [1:0]                         cnt_q;
	logic signed [pcos_pkg::PROD_W-1:0] prod_s1;
	logic                               prod_hi_s1;
	logic [pcos_pkg::ACC_W-1:0]         acc_q;

	logic                      out_valid_q;
	pcos_pkg::out_word_t       out_word_q;

	logic                          accept;
	logic                          in_range;
	logic [AW-1:0]                 in_idx;
	logic [pcos_pkg::ALPHA_W-1:0]  a_sat;
	logic                          known;
	logic [pcos_pkg::STAMP_W-1:0]  ram_rdata;
	logic                          ram_we;
	logic [pcos_pkg::STAMP_W-1:0]  ram_wdata;
	logic signed [pcos_pkg::MUL_X_W-1:0] mul_x;
	logic signed [pcos_pkg::MUL_M_W-1:0] mul_m;
	logic [pcos_pkg::ACC_W-1:0]    acc_term;
	logic                          acc_add;
	logic [pcos_pkg::ACC_W-1:0]    round_sum;
	logic [pcos_pkg::STAMP_W-1:0]  blended;
	logic                          out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_range  = (32'(in_word.sensor_slot) < NUM_SLOTS);
	assign in_idx    = in_word.sensor_slot[AW-1:0];
	// alpha above one saturates to one
	assign a_sat     = alpha_q[pcos_pkg::ALPHA_W-1] ? pcos_pkg::ONE_Q16 : alpha_q;
	assign known     = in_range_q && valid_q[idx_q];
	assign out_free  = !out_valid_q || !out_stall;

	// Offset table; a word reads its entry at acceptance
	pcos_ram #(
		.WIDTH (pcos_pkg::STAMP_W),
		.DEPTH (DEPTH)
	) u_offset_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (idx_q),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (ram_rdata)
	);

	// First observation stores as is; a blend writes back after rounding
	assign ram_we = (state_q == S_ROUND) ||
	                ((state_q == S_LOOK) && (mode_q == pcos_pkg::MODE_OBSERVE) &&
	                 in_range_q && !known);
	assign ram_wdata = (state_q == S_ROUND) ? blended : obs_q;

	// Partial product order: old lo, old hi, obs lo, obs hi
	always_comb begin
		case (cnt_q)
			2'd0:    mul_x = $signed({1'b0, old_q[pcos_pkg::HALF_W-1:0]});
			2'd1:    mul_x = $signed({old_q[pcos_pkg::STAMP_W-1],
			                          old_q[pcos_pkg::STAMP_W-1:pcos_pkg::HALF_W]});
			2'd2:    mul_x = $signed({1'b0, obs_q[pcos_pkg::HALF_W-1:0]});
			default: mul_x = $signed({obs_q[pcos_pkg::STAMP_W-1],
			                          obs_q[pcos_pkg::STAMP_W-1:pcos_pkg::HALF_W]});
		endcase
		mul_m = $signed({1'b0, (cnt_q[1] ? a_q : inv_a_q)});
	end

	// High partial products sit 32 bits up
	assign acc_term = prod_hi_s1
		? {prod_s1[pcos_pkg::ACC_W-pcos_pkg::HALF_W-1:0], {pcos_pkg::HALF_W{1'b0}}}
		: {{(pcos_pkg::ACC_W-pcos_pkg::PROD_W){prod_s1[pcos_pkg::PROD_W-1]}}, prod_s1};
	assign acc_add  = ((state_q == S_MUL) && (cnt_q != 2'd0)) || (state_q == S_ACC);

	// (sum + 32768) >> 16 when positive, (sum + 32767) >>> 16 when negative,
	// which is round half away from zero of sum / 65536
	assign round_sum = acc_q + (acc_q[pcos_pkg::ACC_W-1] ? pcos_pkg::BIAS_NEG
	                                                      : pcos_pkg::BIAS_POS);
	assign blended   = round_sum[pcos_pkg::Q_SHIFT +: pcos_pkg::STAMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alpha_q     <= pcos_pkg::ALPHA_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				alpha_q <= cfg_wr_data;
			end

			// the response state reloads the register itself
			if (out_valid_q && !out_stall && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_word.mode == pcos_pkg::MODE_CLEAR) begin
							valid_q <= '0;
						end else begin
							state_q <= S_LOOK;
						end
						mode_q     <= in_word.mode;
						idx_q      <= in_idx;
						in_range_q <= in_range;
						dev_q      <= in_word.device_stamp;
						obs_q      <= in_word.host_stamp - in_word.device_stamp;
						a_q        <= a_sat;
						inv_a_q    <= pcos_pkg::ONE_Q16 - a_sat;
					end
				end
				S_LOOK: begin
					acc_q   <= '0;
					cnt_q   <= '0;
					old_q   <= ram_rdata;
					known_q <= known;
					off_q   <= known ? ram_rdata : '0;
					if (mode_q != pcos_pkg::MODE_OBSERVE) begin
						state_q <= S_RESP;
					end else if (!in_range_q) begin
						state_q <= S_IDLE;
					end else if (!known) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s1    <= mul_x * mul_m;
					prod_hi_s1 <= cnt_q[0];
					cnt_q      <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_IDLE;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q              <= 1'b1;
						out_word_q.host_estimate <= dev_q + off_q;
						out_word_q.offset_value  <= off_q;
						out_word_q.slot_known    <= known_q;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (acc_add) begin
				acc_q <= acc_q + acc_term;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// A blend runs only for an observe of a known slot
	a_blend_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) && (mode_q == pcos_pkg::MODE_OBSERVE) && known
		|=> (state_q == S_MUL) && (cnt_q == 2'd0))
		else $error("blend did not start for a known slot");

	// Accumulate is entered only from the multiply state after its last partial product
	a_acc_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> ($past(state_q) == S_MUL) && ($past(cnt_q) == 2'd3))
		else $error("accumulate entered out of order");

	// A first observation leaves its slot marked valid
	a_first_obs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) && ram_we |=> valid_q[idx_q])
		else $error("slot not marked valid after first observation");

	// Results come only from the response state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("output word loaded outside response state");

endmodule

`default_nettype wire
